// ----- src/esw_pkg.sv -----
package esw_pkg;

    typedef struct packed {
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] row0_col0;
        logic signed [23:0] row0_col1;
        logic signed [23:0] row0_col2;
        logic signed [23:0] row1_col0;
        logic signed [23:0] row1_col1;
        logic signed [23:0] row1_col2;
        logic signed [23:0] row2_col0;
        logic signed [23:0] row2_col1;
        logic signed [23:0] row2_col2;
        logic signed [23:0] trans_x;
        logic signed [23:0] trans_y;
        logic signed [23:0] trans_z;
    } t_out_word;

    // sine polynomial coefficients, Q30
    localparam logic signed [31:0] C_A1 = 32'sd1686629713;
    localparam logic signed [31:0] C_A3 = -32'sd693598668;
    localparam logic signed [31:0] C_A5 = 32'sd85569306;
    localparam logic signed [31:0] C_A7 = -32'sd5026995;
    localparam logic signed [31:0] C_A9 = 32'sd172272;
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

endpackage

// ----- src/euler_srt_world_matrix.sv -----
// channel | signals                    | accepted when
// input   | i_valid, o_ready, i_data   | i_valid && o_ready
// output  | o_valid, i_ready, o_data   | o_valid && i_ready
// one matrix per cycle while the output is not stalled; eleven register stages, so a word
// accepted at the input passes through each stage in turn before it shows on o_valid
// stages: angle split, horner steps, trig rounding, pair products, matrix rounding, scaling, saturate
// synchronous active-low reset clears all stage valid bits
// a stall holds each full stage back to the first empty one; a stage moves when the stage after it is empty or moving
module euler_srt_world_matrix
    import esw_pkg::*;
#(
    parameter int TRIG_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int NS  = 11;
    localparam int TB  = TRIG_BITS;
    localparam int TW  = TB + 2;            // signed trig width
    localparam int MW  = 3 * TB + 4;        // matrix exact width
    localparam int SH  = 2 * TB;

    // six horner lanes: sx cx sy cy sz cz
    typedef struct packed {
        logic signed [31:0] t;
        logic signed [31:0] t2;
        logic signed [31:0] p;
        logic [1:0]         quad;
    } t_lane;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // side-band carried along: scales and positions
    logic signed [23:0] r_sc [NS-1:0][2:0];
    logic signed [23:0] r_ps [NS-1:0][2:0];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_sc[0][0] <= i_data.scale_x;
            r_sc[0][1] <= i_data.scale_y;
            r_sc[0][2] <= i_data.scale_z;
            r_ps[0][0] <= i_data.pos_x;
            r_ps[0][1] <= i_data.pos_y;
            r_ps[0][2] <= i_data.pos_z;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_sc[k] <= r_sc[k-1];
                r_ps[k] <= r_ps[k-1];
            end
        end
    end

    // stage 0: angle split, t and t^2
    t_lane r_l0 [5:0];
    logic [15:0] ang [5:0];
    always_comb begin
        ang[0] = i_data.angle_x;
        ang[1] = i_data.angle_x + 16'd16384;
        ang[2] = i_data.angle_y;
        ang[3] = i_data.angle_y + 16'd16384;
        ang[4] = i_data.angle_z;
        ang[5] = i_data.angle_z + 16'd16384;
    end

    always_ff @(posedge i_clk) begin
        logic [14:0] x;
        logic signed [63:0] tt;
        if (adv[0]) begin
            for (int j = 0; j < 6; j++) begin
                x = ang[j][14] ? (15'd16384 - {1'b0, ang[j][13:0]})
                               : {1'b0, ang[j][13:0]};
                tt = $signed({33'd0, x, 16'd0}) * $signed({33'd0, x, 16'd0});
                r_l0[j].t    <= $signed({1'b0, x, 16'd0});
                r_l0[j].t2   <= 32'(tt >>> 30);
                r_l0[j].p    <= C_A9;
                r_l0[j].quad <= ang[j][15:14];
            end
        end
    end

    // stages 1..5: horner, one step each; stage 5 does p*t
    t_lane r_hl [5:1][5:0];

    function automatic logic signed [31:0] coef(input int k);
        case (k)
            1:       coef = C_A7;
            2:       coef = C_A5;
            3:       coef = C_A3;
            default: coef = C_A1;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        logic signed [63:0] pr;
        t_lane nl;
        if (adv[1]) begin
            for (int j = 0; j < 6; j++) begin
                pr = 64'(r_l0[j].p) * 64'(r_l0[j].t2);
                nl = r_l0[j];
                nl.p = 32'(64'(coef(1)) + (pr >>> 30));
                r_hl[1][j] <= nl;
            end
        end
        for (int k = 2; k <= 5; k++) begin
            if (adv[k]) begin
                for (int j = 0; j < 6; j++) begin
                    nl = r_hl[k-1][j];
                    if (k < 5) begin
                        pr = 64'(r_hl[k-1][j].p) * 64'(r_hl[k-1][j].t2);
                        nl.p = 32'(64'(coef(k)) + (pr >>> 30));
                    end else begin
                        pr = 64'(r_hl[k-1][j].p) * 64'(r_hl[k-1][j].t);
                        nl.p = 32'(pr >>> 30);
                    end
                    r_hl[k][j] <= nl;
                end
            end
        end
    end

    // stage 6: round, clamp, sign
    logic signed [TW-1:0] r_tr [5:0];
    always_ff @(posedge i_clk) begin
        logic signed [32:0] rr;
        logic signed [32:0] one;
        if (adv[6]) begin
            for (int j = 0; j < 6; j++) begin
                one = 33'sd1 <<< TB;
                rr = (33'(r_hl[5][j].p) + (33'sd1 <<< (29 - TB))) >>> (30 - TB);
                if (rr < 0) rr = '0;
                if (rr > one) rr = one;
                if (r_hl[5][j].quad[1]) rr = -rr;
                r_tr[j] <= TW'(rr);
            end
        end
    end

    // stage 7: pair products Q(2TB)
    logic signed [2*TW-1:0] r_pp [9:0];
    // 0 cy*cz 1 cy*sz 2 sx*sy 3 cx*sz 4 cx*cz 5 sx*cy 6 cx*sy 7 sx*sz 8 sx*cz 9 cx*cy
    logic signed [TW-1:0] r_sy7, r_sz7, r_cz7;
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_pp[0] <= r_tr[3] * r_tr[5];
            r_pp[1] <= r_tr[3] * r_tr[4];
            r_pp[2] <= r_tr[0] * r_tr[2];
            r_pp[3] <= r_tr[1] * r_tr[4];
            r_pp[4] <= r_tr[1] * r_tr[5];
            r_pp[5] <= r_tr[0] * r_tr[3];
            r_pp[6] <= r_tr[1] * r_tr[2];
            r_pp[7] <= r_tr[0] * r_tr[4];
            r_pp[8] <= r_tr[0] * r_tr[5];
            r_pp[9] <= r_tr[1] * r_tr[3];
            r_sy7   <= r_tr[2];
            r_sz7   <= r_tr[4];
            r_cz7   <= r_tr[5];
        end
    end

    // stage 8: entries in Q(3TB), rounded to Q(TB)
    logic signed [TW+1:0] r_m [8:0];
    function automatic logic signed [TW+1:0] rnd_m(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] s;
        s = (v + (MW'(1) <<< (SH - 1))) >>> SH;
        rnd_m = (TW+2)'(s);
    endfunction
    always_ff @(posedge i_clk) begin
        logic signed [MW-1:0] lf [9:0];
        if (adv[8]) begin
            for (int j = 0; j < 10; j++) begin
                lf[j] = MW'(r_pp[j]) <<< TB;
            end
            r_m[0] <= rnd_m(lf[0]);
            r_m[1] <= rnd_m(lf[1]);
            r_m[2] <= rnd_m(-(MW'(r_sy7) <<< SH));
            r_m[3] <= rnd_m(MW'(r_pp[2]) * MW'(r_cz7) - lf[3]);
            r_m[4] <= rnd_m(MW'(r_pp[2]) * MW'(r_sz7) + lf[4]);
            r_m[5] <= rnd_m(lf[5]);
            r_m[6] <= rnd_m(MW'(r_pp[6]) * MW'(r_cz7) + lf[7]);
            r_m[7] <= rnd_m(MW'(r_pp[6]) * MW'(r_sz7) - lf[8]);
            r_m[8] <= rnd_m(lf[9]);
        end
    end

    // stage 9: scale product
    logic signed [24+TW+1:0] r_sp [8:0];
    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            for (int j = 0; j < 9; j++) begin
                r_sp[j] <= (26+TW)'(r_sc[8][j/3]) * (26+TW)'(r_m[j]);
            end
        end
    end

    // stage 10: round and saturate
    logic signed [23:0] r_o [8:0];
    always_ff @(posedge i_clk) begin
        logic signed [24+TW+1:0] v;
        if (adv[10]) begin
            for (int j = 0; j < 9; j++) begin
                v = (r_sp[j] + ((26+TW)'(1) <<< (TB - 1))) >>> TB;
                if (v > OUT_MAX) v = (26+TW)'(OUT_MAX);
                if (v < OUT_MIN) v = (26+TW)'(OUT_MIN);
                r_o[j] <= v[23:0];
            end
        end
    end

    assign o_valid          = r_vld[NS-1];
    assign o_data.row0_col0 = r_o[0];
    assign o_data.row0_col1 = r_o[1];
    assign o_data.row0_col2 = r_o[2];
    assign o_data.row1_col0 = r_o[3];
    assign o_data.row1_col1 = r_o[4];
    assign o_data.row1_col2 = r_o[5];
    assign o_data.row2_col0 = r_o[6];
    assign o_data.row2_col1 = r_o[7];
    assign o_data.row2_col2 = r_o[8];
    assign o_data.trans_x   = r_ps[NS-1][0];
    assign o_data.trans_y   = r_ps[NS-1][1];
    assign o_data.trans_z   = r_ps[NS-1][2];

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> o_ready) else $error("ready low with empty output stage");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output lost on stall");
    a_stall_blocks_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_ready |-> !o_ready) else $error("entry taken with full pipe");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import esw_pkg::*;

    localparam int TB = 14;
    localparam int LIMIT = 200000;
    localparam int N_RANDOM = 600;
    localparam int IN_W = $bits(t_in_word);

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    euler_srt_world_matrix #(.TRIG_BITS(TB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    t_out_word matrix_q[$];
    int        errors = 0;
    int        cycles = 0;
    int        n_sent = 0;
    int        n_seen = 0;
    bit        calm;
    bit        hold_rx;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd(longint v, int n);
        return asr(v + (64'sd1 <<< (n - 1)), n);
    endfunction

    function automatic longint sin_q(logic [15:0] ang);
        longint x, t, t2, p, s, r;
        logic [1:0] quad;
        quad = ang[15:14];
        x = longint'(ang[13:0]);
        if (quad[0]) x = 16384 - x;
        t = x * 65536;
        t2 = asr(t * t, 30);
        p = longint'(C_A9);
        p = longint'(C_A7) + asr(p * t2, 30);
        p = longint'(C_A5) + asr(p * t2, 30);
        p = longint'(C_A3) + asr(p * t2, 30);
        p = longint'(C_A1) + asr(p * t2, 30);
        s = asr(p * t, 30);
        r = rnd(s, 30 - TB);
        if (r < 0) r = 0;
        if (r > (64'sd1 <<< TB)) r = 64'sd1 <<< TB;
        if (quad[1]) r = -r;
        return r;
    endfunction

    function automatic logic signed [23:0] scaled(logic signed [23:0] sc, longint m);
        longint v;
        v = rnd(longint'(sc) * m, TB);
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        return v[23:0];
    endfunction

    function automatic t_out_word world_matrix(t_in_word w);
        longint sx, cx, sy, cy, sz, cz, one;
        longint m[9];
        t_out_word r;
        one = 64'sd1 <<< TB;
        sx = sin_q(w.angle_x); cx = sin_q(w.angle_x + 16'd16384);
        sy = sin_q(w.angle_y); cy = sin_q(w.angle_y + 16'd16384);
        sz = sin_q(w.angle_z); cz = sin_q(w.angle_z + 16'd16384);
        m[0] = rnd(cy * cz * one, 2 * TB);
        m[1] = rnd(cy * sz * one, 2 * TB);
        m[2] = rnd(-sy * one * one, 2 * TB);
        m[3] = rnd(sx * sy * cz - cx * sz * one, 2 * TB);
        m[4] = rnd(sx * sy * sz + cx * cz * one, 2 * TB);
        m[5] = rnd(sx * cy * one, 2 * TB);
        m[6] = rnd(cx * sy * cz + sx * sz * one, 2 * TB);
        m[7] = rnd(cx * sy * sz - sx * cz * one, 2 * TB);
        m[8] = rnd(cx * cy * one, 2 * TB);
        r.row0_col0 = scaled(w.scale_x, m[0]);
        r.row0_col1 = scaled(w.scale_x, m[1]);
        r.row0_col2 = scaled(w.scale_x, m[2]);
        r.row1_col0 = scaled(w.scale_y, m[3]);
        r.row1_col1 = scaled(w.scale_y, m[4]);
        r.row1_col2 = scaled(w.scale_y, m[5]);
        r.row2_col0 = scaled(w.scale_z, m[6]);
        r.row2_col1 = scaled(w.scale_z, m[7]);
        r.row2_col2 = scaled(w.scale_z, m[8]);
        r.trans_x = w.pos_x;
        r.trans_y = w.pos_y;
        r.trans_z = w.pos_z;
        return r;
    endfunction

    // directed rows: angles, scales, positions; expected typed in for identity rows
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_row;

    t_row rows[$];

    function automatic t_in_word mk(int s0, int s1, int s2, int a0, int a1, int a2,
                                    int p0, int p1, int p2);
        t_in_word w;
        w.scale_x = 24'(s0); w.scale_y = 24'(s1); w.scale_z = 24'(s2);
        w.angle_x = 16'(a0); w.angle_y = 16'(a1); w.angle_z = 16'(a2);
        w.pos_x = 24'(p0); w.pos_y = 24'(p1); w.pos_z = 24'(p2);
        return w;
    endfunction

    task automatic add_row(t_in_word w, bit typed, t_out_word want);
        t_row r;
        r.word = w; r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    function automatic t_out_word diag(int s0, int s1, int s2, int p0, int p1, int p2);
        t_out_word r;
        r = '0;
        r.row0_col0 = 24'(s0); r.row1_col1 = 24'(s1); r.row2_col2 = 24'(s2);
        r.trans_x = 24'(p0); r.trans_y = 24'(p1); r.trans_z = 24'(p2);
        return r;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int k;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        k = $urandom_range(0, 9);
        // quarter-turn and axis angles are where clamping and sign flips live
        if (k == 0) w.angle_x = {2'($urandom_range(0, 3)), 14'd0};
        if (k == 1) w.angle_y = {2'($urandom_range(0, 3)), 14'd0};
        if (k == 2) w.angle_z = {2'($urandom_range(0, 3)), 14'd0};
        if (k == 3) w.scale_x = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
        if (k == 4) begin
            w.scale_x = 24'($urandom_range(0, 131072) - 65536);
            w.scale_y = 24'($urandom_range(0, 131072) - 65536);
            w.scale_z = 24'($urandom_range(0, 131072) - 65536);
        end
        return w;
    endfunction

    task automatic send(t_in_word w);
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic idle_tx();
        int g;
        if (!calm && $urandom_range(0, 3) == 0) begin
            g = $urandom_range(1, 3);
            i_valid <= 1'b0;
            i_data  <= rand_word();
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result check against oldest expected matrix
    always @(posedge i_clk) begin
        t_out_word w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            n_seen++;
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_data);
                errors++;
            end else begin
                w = matrix_q.pop_front();
                if (o_data.row0_col0 !== w.row0_col0)
                    $display("%0t: row0_col0 exp %0d got %0d", $time,
                             w.row0_col0, o_data.row0_col0);
                if (o_data.row0_col1 !== w.row0_col1)
                    $display("%0t: row0_col1 exp %0d got %0d", $time,
                             w.row0_col1, o_data.row0_col1);
                if (o_data.row0_col2 !== w.row0_col2)
                    $display("%0t: row0_col2 exp %0d got %0d", $time,
                             w.row0_col2, o_data.row0_col2);
                if (o_data.row1_col0 !== w.row1_col0)
                    $display("%0t: row1_col0 exp %0d got %0d", $time,
                             w.row1_col0, o_data.row1_col0);
                if (o_data.row1_col1 !== w.row1_col1)
                    $display("%0t: row1_col1 exp %0d got %0d", $time,
                             w.row1_col1, o_data.row1_col1);
                if (o_data.row1_col2 !== w.row1_col2)
                    $display("%0t: row1_col2 exp %0d got %0d", $time,
                             w.row1_col2, o_data.row1_col2);
                if (o_data.row2_col0 !== w.row2_col0)
                    $display("%0t: row2_col0 exp %0d got %0d", $time,
                             w.row2_col0, o_data.row2_col0);
                if (o_data.row2_col1 !== w.row2_col1)
                    $display("%0t: row2_col1 exp %0d got %0d", $time,
                             w.row2_col1, o_data.row2_col1);
                if (o_data.row2_col2 !== w.row2_col2)
                    $display("%0t: row2_col2 exp %0d got %0d", $time,
                             w.row2_col2, o_data.row2_col2);
                if (o_data.trans_x !== w.trans_x)
                    $display("%0t: trans_x exp %0d got %0d", $time,
                             w.trans_x, o_data.trans_x);
                if (o_data.trans_y !== w.trans_y)
                    $display("%0t: trans_y exp %0d got %0d", $time,
                             w.trans_y, o_data.trans_y);
                if (o_data.trans_z !== w.trans_z)
                    $display("%0t: trans_z exp %0d got %0d", $time,
                             w.trans_z, o_data.trans_z);
                if (o_data !== w) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("%0t: timeout", $time);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int i;
        calm = 1'b0; hold_rx = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, diag(0, 0, 0, 0, 0, 0));
        add_row(mk(65536, 65536, 65536, 0, 0, 0, 1, -1, 2), 1,
                diag(65536, 65536, 65536, 1, -1, 2));
        add_row(mk(8388607, 8388607, 8388607, 0, 0, 0, 8388607, 8388607, 8388607), 1,
                diag(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        add_row(mk(-8388608, -8388608, -8388608, 0, 0, 0, -8388608, -8388608, -8388608), 1,
                diag(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
        add_row(mk(65536, 65536, 65536, 16384, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 0, 16384, 0, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 0, 0, 16384, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 32768, 32768, 32768, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 49152, 49152, 49152, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 65535, 65535, 65535, 0, 0, 0), 0, '0);
        add_row(mk(65536, 65536, 65536, 1, 16383, 16385, 0, 0, 0), 0, '0);
        add_row(mk(8388607, -8388608, 8388607, 8192, 24576, 40960, 5, 6, 7), 0, '0);
        add_row(mk(-8388608, 8388607, -8388608, 57344, 8192, 12345, 0, 0, 0), 0, '0);
        add_row(mk(-1, 1, -65536, 12000, 33000, 51000, -5, 9, 0), 0, '0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < rows.size(); i++) begin
            matrix_q.push_back(rows[i].typed ? rows[i].want : world_matrix(rows[i].word));
            send(rows[i].word);
            idle_tx();
        end
        i_valid <= 1'b0;

        // sender pauses until the pipeline drains
        while (matrix_q.size() != 0) @(posedge i_clk);

        // long receiver hold-off while the sender keeps offering
        hold_rx = 1'b1;
        fork
            begin
                repeat (40) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 30; k++) begin
                t_in_word w;
                w = rand_word();
                matrix_q.push_back(world_matrix(w));
                send(w);
            end
        join
        i_valid <= 1'b0;

        for (i = 0; i < N_RANDOM; i++) begin
            t_in_word w;
            if (i == N_RANDOM - 100) calm = 1'b1;
            w = rand_word();
            matrix_q.push_back(world_matrix(w));
            send(w);
            idle_tx();
        end
        i_valid <= 1'b0;

        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d of %0d matrices: identity, extremes, quarter turns, saturation,",
                 n_seen, n_sent);
        $display("random angles and scales, random stalls and a long output hold-off");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- euler_srt_world_matrix.f -----
src/esw_pkg.sv
src/euler_srt_world_matrix.sv
verif/tb.sv
